[src/twd_pkg.sv]
// shared constants and types for the wrapped distance block
`default_nettype none
package twd_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int LEN_BITS           = 16;
   localparam int CSR_INDEX_BITS     = 1;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 16'd4096;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PLOT_LENGTH_X = 1'b0,
      CSR_PLOT_LENGTH_Y = 1'b1
   } csr_index_type;

endpackage
`default_nettype wire

[src/twd_gap_pipe.sv]
// four stage front end: wrapped gap per axis, squares and their sum
`default_nettype none
module twd_gap_pipe
   import twd_pkg::*;
#(
   parameter int CB = COORD_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [CB-1:0]       from_x,
   input  wire logic [CB-1:0]       from_y,
   input  wire logic [CB-1:0]       to_x,
   input  wire logic [CB-1:0]       to_y,
   input  wire logic [LEN_BITS-1:0] len_x,
   input  wire logic [LEN_BITS-1:0] len_y,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [2*CB:0]            out_sum
);

   localparam int SW = 2 * CB + 1;

   logic [3:0] v_ff;
   logic [3:0] v_in;
   logic [3:0] rdy;

   logic [CB-1:0]          dir_x_ff, dir_y_ff;
   logic signed [CB+1:0]   wrap_x_ff, wrap_y_ff;
   logic [CB-1:0]          mag_x_ff, mag_y_ff;
   logic [CB-1:0]          mag_x_in, mag_y_in;
   logic [2*CB-1:0]        sq_x_ff, sq_y_ff;
   logic [SW-1:0]          sum_ff;

   function automatic logic [CB-1:0] direct_gap(input logic [CB-1:0] f, input logic [CB-1:0] t);
      logic [CB-1:0] mx;
      logic [CB-1:0] mn;
      begin
         mx = (t > f) ? t : f;
         mn = (t > f) ? f : t;
         return mx - mn;
      end
   endfunction

   function automatic logic signed [CB+1:0] wrap_gap(input logic [CB-1:0] f,
                                                     input logic [CB-1:0] t,
                                                     input logic [CB-1:0] l);
      logic [CB-1:0] mx;
      logic [CB-1:0] mn;
      begin
         mx = (t > f) ? t : f;
         mn = (t > f) ? f : t;
         return $signed({2'b00, mn}) + $signed({2'b00, l}) - $signed({2'b00, mx});
      end
   endfunction

   function automatic logic [CB-1:0] kept_mag(input logic [CB-1:0] d,
                                              input logic signed [CB+1:0] w);
      logic signed [CB+1:0] kept;
      logic signed [CB+1:0] pos;
      begin
         kept = ($signed({2'b00, d}) < w) ? $signed({2'b00, d}) : w;
         pos  = kept[CB+1] ? -kept : kept;
         return pos[CB-1:0];
      end
   endfunction

   // ready ripples back, so bubbles collapse while the output stalls
   assign rdy[3]   = !v_ff[3] || out_ready;
   assign rdy[2]   = !v_ff[2] || rdy[3];
   assign rdy[1]   = !v_ff[1] || rdy[2];
   assign rdy[0]   = !v_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_comb begin
      v_in[0] = rdy[0] ? in_valid : v_ff[0];
      v_in[1] = rdy[1] ? v_ff[0]  : v_ff[1];
      v_in[2] = rdy[2] ? v_ff[1]  : v_ff[2];
      v_in[3] = rdy[3] ? v_ff[2]  : v_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign mag_x_in = kept_mag(dir_x_ff, wrap_x_ff);
   assign mag_y_in = kept_mag(dir_y_ff, wrap_y_ff);

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         dir_x_ff  <= direct_gap(from_x, to_x);
         dir_y_ff  <= direct_gap(from_y, to_y);
         wrap_x_ff <= wrap_gap(from_x, to_x, CB'(len_x));
         wrap_y_ff <= wrap_gap(from_y, to_y, CB'(len_y));
      end
      if (rdy[1]) begin
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
      end
      if (rdy[2]) begin
         sq_x_ff <= (2*CB)'(mag_x_ff) * (2*CB)'(mag_x_ff);
         sq_y_ff <= (2*CB)'(mag_y_ff) * (2*CB)'(mag_y_ff);
      end
      if (rdy[3]) begin
         sum_ff <= SW'(sq_x_ff) + SW'(sq_y_ff);
      end
   end

   assign out_valid = v_ff[3];
   assign out_sum   = sum_ff;

   a_mag_x_bound: assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && rdy[1]) |=> (mag_x_ff <= $past(dir_x_ff)))
      else $error("x gap exceeds direct gap");

   a_mag_y_bound: assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && rdy[1]) |=> (mag_y_ff <= $past(dir_y_ff)))
      else $error("y gap exceeds direct gap");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (v_ff == 4'b0000))
      else $error("front end not empty after reset");

endmodule
`default_nettype wire

[src/twd_isqrt_pipe.sv]
// pipelined restoring square root, one root bit per stage
`default_nettype none
module twd_isqrt_pipe
   import twd_pkg::*;
#(
   parameter int CB = COORD_BITS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [2*CB:0] in_sum,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [CB:0]        out_root
);

   localparam int R   = CB + 1;
   localparam int SW  = 2 * CB + 1;
   localparam int PW  = 2 * R;
   localparam int RW  = R + 2;
   localparam int SQW = 2 * R + 1;

   logic [R-1:0]  v_ff;
   logic [R-1:0]  rdy;
   logic [SW-1:0] sum_ff  [R];
   logic [RW-1:0] rem_ff  [R];
   logic [R-1:0]  root_ff [R];

   genvar k;
   generate
      for (k = 0; k < R; k++) begin : g_stage
         localparam int P = R - 1 - k;

         logic          v_src;
         logic [SW-1:0] sum_src;
         logic [RW-1:0] rem_src;
         logic [R-1:0]  root_src;
         logic [PW-1:0] padded;
         logic [1:0]    two;
         logic [RW-1:0] rem_sh;
         logic [RW-1:0] trial;
         logic [RW-1:0] rem_in;
         logic [R-1:0]  root_in;

         if (k == 0) begin : g_first
            assign v_src    = in_valid;
            assign sum_src  = in_sum;
            assign rem_src  = '0;
            assign root_src = '0;
         end else begin : g_next
            assign v_src    = v_ff[k-1];
            assign sum_src  = sum_ff[k-1];
            assign rem_src  = rem_ff[k-1];
            assign root_src = root_ff[k-1];
         end

         if (k == R - 1) begin : g_last_rdy
            assign rdy[k] = !v_ff[k] || out_ready;
         end else begin : g_mid_rdy
            assign rdy[k] = !v_ff[k] || rdy[k+1];
         end

         always_comb begin
            padded = PW'(sum_src);
            two    = padded[2*P+1 -: 2];
            rem_sh = {rem_src[RW-3:0], two};
            trial  = {root_src, 2'b01};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_src[R-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_src[R-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               v_ff[k] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               sum_ff[k]  <= sum_src;
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
            end
         end
      end
   endgenerate

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[R-1];
   assign out_root  = root_ff[R-1];

   a_root_low: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ((SQW'(out_root) * SQW'(out_root)) <= SQW'(sum_ff[R-1])))
      else $error("root too large");

   a_root_high: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (((SQW'(out_root) + 1'b1) * (SQW'(out_root) + 1'b1))
                     > SQW'(sum_ff[R-1])))
      else $error("root too small");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (v_ff == '0))
      else $error("root pipeline not empty after reset");

endmodule
`default_nettype wire

[src/torus_wrapped_distance.sv]
// top level: wrapped distance between two points on a torus shaped plot
//
// req channel carries one point pair per item (from_x, from_y, to_x, to_y),
// unsigned fixed point with four fraction bits. rsp channel returns one item
// per request, the floor of the wrapped euclidean distance, one bit wider.
// both channels use valid/ready; a transfer happens when both are high.
// path from request transfer to rsp_valid: four front end stages (gaps,
// kept magnitude, squares, sum) and one square root stage per result bit.
// a new item is taken every cycle while the pipeline does not stall.
// when rsp_ready is low the last stage holds its item; ready ripples back
// stage by stage so empty stages keep filling until the pipeline is full.
// csr write port sets the two plot lengths, no read back.
// the user writes plot lengths only while the pipeline is empty; the block does not enforce it.
// synchronous reset empties the pipeline and sets both lengths to 4096.
`default_nettype none
module torus_wrapped_distance
   import twd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [COORD_BITS-1:0]     req_from_x,
   input  wire logic [COORD_BITS-1:0]     req_from_y,
   input  wire logic [COORD_BITS-1:0]     req_to_x,
   input  wire logic [COORD_BITS-1:0]     req_to_y,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [COORD_BITS:0]            rsp_distance,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [LEN_BITS-1:0]       csr_wdata
);

   logic [LEN_BITS-1:0]   len_x_ff, len_y_ff;
   logic                  sum_valid;
   logic                  sum_ready;
   logic [2*COORD_BITS:0] sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_x_ff <= LEN_RESET;
         len_y_ff <= LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PLOT_LENGTH_X: len_x_ff <= csr_wdata;
            CSR_PLOT_LENGTH_Y: len_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   twd_gap_pipe #(
      .CB (COORD_BITS)
   ) u_gap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .from_x    (req_from_x),
      .from_y    (req_from_y),
      .to_x      (req_to_x),
      .to_y      (req_to_y),
      .len_x     (len_x_ff),
      .len_y     (len_y_ff),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sum)
   );

   twd_isqrt_pipe #(
      .CB (COORD_BITS)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_sum    (sum),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_root  (rsp_distance)
   );

endmodule
`default_nettype wire

[tb/torus_wrapped_distance_tb.sv]
// testbench for the wrapped distance block: directed and random point pairs against a predictor
`default_nettype none
module torus_wrapped_distance_tb
   import twd_pkg::*;
();

   localparam int COORD_BITS  = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [COORD_BITS-1:0]   req_from_x;
   logic [COORD_BITS-1:0]   req_from_y;
   logic [COORD_BITS-1:0]   req_to_x;
   logic [COORD_BITS-1:0]   req_to_y;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [COORD_BITS:0]     rsp_distance;
   logic                    csr_we;
   csr_index_type           csr_index;
   logic [LEN_BITS-1:0]     csr_wdata;

   logic [LEN_BITS-1:0]     plot_len_x;
   logic [LEN_BITS-1:0]     plot_len_y;
   logic [COORD_BITS:0]     expected_distances[$];
   int                      error_count;
   int                      cycle_count;
   bit                      sender_idles;
   bit                      receiver_idles;
   bit                      hold_off_request;

   torus_wrapped_distance #(.COORD_BITS(COORD_BITS)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_from_x   (req_from_x),
      .req_from_y   (req_from_y),
      .req_to_x     (req_to_x),
      .req_to_y     (req_to_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // magnitude of the smaller signed candidate gap on one axis
   function automatic logic [COORD_BITS-1:0] kept_gap(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b,
                                                      input logic [LEN_BITS-1:0] len);
      logic signed [COORD_BITS+1:0] direct;
      logic signed [COORD_BITS+1:0] wrapped;
      logic signed [COORD_BITS+1:0] kept;
      if (b > a) begin
         direct  = $signed({2'b00, b}) - $signed({2'b00, a});
         wrapped = $signed({2'b00, a}) + $signed({2'b00, len}) - $signed({2'b00, b});
      end else begin
         direct  = $signed({2'b00, a}) - $signed({2'b00, b});
         wrapped = $signed({2'b00, b}) + $signed({2'b00, len}) - $signed({2'b00, a});
      end
      kept = (direct < wrapped) ? direct : wrapped;
      return (kept < 0) ? COORD_BITS'(-kept) : COORD_BITS'(kept);
   endfunction

   function automatic logic [COORD_BITS:0] floor_sqrt(input logic [2*COORD_BITS:0] value);
      logic [2*COORD_BITS+1:0] padded;
      logic [2*COORD_BITS+1:0] rem;
      logic [2*COORD_BITS+1:0] trial;
      logic [COORD_BITS:0]     root;
      padded = {1'b0, value};
      rem    = '0;
      root   = '0;
      for (int i = COORD_BITS; i >= 0; i--) begin
         rem   = (rem << 2) | padded[2*i +: 2];
         trial = {root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[COORD_BITS-1:0], 1'b1};
         end else begin
            root = {root[COORD_BITS-1:0], 1'b0};
         end
      end
      return root;
   endfunction

   function automatic logic [COORD_BITS:0] torus_distance(input logic [COORD_BITS-1:0] fx,
                                                          input logic [COORD_BITS-1:0] fy,
                                                          input logic [COORD_BITS-1:0] tx,
                                                          input logic [COORD_BITS-1:0] ty);
      logic [COORD_BITS-1:0]   gx;
      logic [COORD_BITS-1:0]   gy;
      logic [2*COORD_BITS-1:0] sq_x;
      logic [2*COORD_BITS-1:0] sq_y;
      gx   = kept_gap(fx, tx, plot_len_x);
      gy   = kept_gap(fy, ty, plot_len_y);
      sq_x = (2*COORD_BITS)'(gx) * (2*COORD_BITS)'(gx);
      sq_y = (2*COORD_BITS)'(gy) * (2*COORD_BITS)'(gy);
      return floor_sqrt((2*COORD_BITS+1)'(sq_x) + (2*COORD_BITS+1)'(sq_y));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random coordinate, mostly inside the plot, sometimes anywhere
   function automatic logic [COORD_BITS-1:0] pick_coord(input logic [LEN_BITS-1:0] len);
      if (len == 0 || $urandom_range(0, 3) == 0) return COORD_BITS'($urandom);
      return COORD_BITS'($urandom_range(0, int'(len) - 1));
   endfunction

   task automatic send_pair(input logic [COORD_BITS-1:0] fx, input logic [COORD_BITS-1:0] fy,
                            input logic [COORD_BITS-1:0] tx, input logic [COORD_BITS-1:0] ty);
      int gap;
      gap = sender_idles ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_from_x <= fx;
      req_from_y <= fy;
      req_to_x   <= tx;
      req_to_y   <= ty;
      do @(posedge clock); while (!req_ready);
      expected_distances.push_back(torus_distance(fx, fy, tx, ty));
   endtask

   task automatic send_random_pairs(input int count);
      repeat (count) begin
         send_pair(pick_coord(plot_len_x), pick_coord(plot_len_y),
                   pick_coord(plot_len_x), pick_coord(plot_len_y));
      end
   endtask

   // lower valid right after the last item and wait until every result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_distances.size() != 0) @(posedge clock);
      repeat (COORD_BITS + 8) @(posedge clock);
   endtask

   task automatic write_plot_length(input csr_index_type index, input logic [LEN_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_PLOT_LENGTH_X) plot_len_x = value;
      else plot_len_y = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_lengths();
      send_pair(16'd0, 16'd0, 16'd0, 16'd0);
      send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_pair(16'd100, 16'd200, 16'd300, 16'd50);
      // coordinates past the plot length give a negative wrapped gap
      send_pair(16'hffff, 16'd0, 16'd0, 16'hffff);
      send_pair(16'd5000, 16'd40000, 16'd4095, 16'd3);
      // equal candidates on both axes
      send_pair(16'd0, 16'd2048, 16'd2048, 16'd0);
      send_pair(16'd0, 16'd0, 16'd4095, 16'd1);
      send_pair(16'haaaa, 16'h5555, 16'h5555, 16'haaaa);
      wait_drained();
   endtask

   task automatic test_length_extremes();
      write_plot_length(CSR_PLOT_LENGTH_X, 16'd0);
      write_plot_length(CSR_PLOT_LENGTH_Y, 16'd0);
      // largest distance the block can produce
      send_pair(16'd0, 16'd0, 16'hffff, 16'hffff);
      send_pair(16'd1234, 16'd77, 16'd1234, 16'd9000);
      send_pair(16'hffff, 16'd1, 16'd0, 16'd0);
      wait_drained();
      write_plot_length(CSR_PLOT_LENGTH_X, 16'd1);
      write_plot_length(CSR_PLOT_LENGTH_Y, 16'hffff);
      send_pair(16'd0, 16'd0, 16'd0, 16'hffff);
      send_pair(16'd0, 16'd0, 16'd1, 16'd32767);
      send_pair(16'hffff, 16'd32768, 16'd0, 16'd0);
      wait_drained();
      write_plot_length(CSR_PLOT_LENGTH_X, 16'hffff);
      write_plot_length(CSR_PLOT_LENGTH_Y, 16'd1);
      send_pair(16'd0, 16'd1, 16'hfffe, 16'd0);
      send_pair(16'd32767, 16'hffff, 16'd0, 16'h0000);
      send_pair(16'hffff, 16'hffff, 16'd0, 16'd0);
      wait_drained();
   endtask

   task automatic test_random_lengths();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_plot_length(CSR_PLOT_LENGTH_X, 16'd4096);
               write_plot_length(CSR_PLOT_LENGTH_Y, 16'd4096);
            end
            1: begin
               write_plot_length(CSR_PLOT_LENGTH_X, 16'hffff);
               write_plot_length(CSR_PLOT_LENGTH_Y, 16'hffff);
            end
            2: begin
               write_plot_length(CSR_PLOT_LENGTH_X, 16'd1);
               write_plot_length(CSR_PLOT_LENGTH_Y, 16'd0);
            end
            default: begin
               write_plot_length(CSR_PLOT_LENGTH_X, LEN_BITS'($urandom));
               write_plot_length(CSR_PLOT_LENGTH_Y, LEN_BITS'($urandom_range(1, 2000)));
            end
         endcase
         send_random_pairs(50);
         wait_drained();
      end
   endtask

   // receiver holds off while the sender keeps offering items back to back
   task automatic test_back_pressure();
      bit saved_idles;
      saved_idles      = sender_idles;
      sender_idles     = 1'b0;
      write_plot_length(CSR_PLOT_LENGTH_X, LEN_BITS'($urandom));
      write_plot_length(CSR_PLOT_LENGTH_Y, LEN_BITS'($urandom));
      hold_off_request = 1'b1;
      send_random_pairs(60);
      sender_idles     = saved_idles;
      wait_drained();
   endtask

   task automatic test_full_rate();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      send_random_pairs(60);
      wait_drained();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_from_x       = '0;
      req_from_y       = '0;
      req_to_x         = '0;
      req_to_y         = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_PLOT_LENGTH_X;
      csr_wdata        = '0;
      plot_len_x       = LEN_RESET;
      plot_len_y       = LEN_RESET;
      error_count      = 0;
      sender_idles     = 1'b1;
      receiver_idles   = 1'b1;
      hold_off_request = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_lengths();
      test_length_extremes();
      test_random_lengths();
      test_back_pressure();
      test_full_rate();
      if (error_count == 0) begin
         $display("torus_wrapped_distance_tb OK");
      end else begin
         $display("torus_wrapped_distance_tb NOT OK");
      end
      $finish;
   end

   initial begin
      int r;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!receiver_idles) begin
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_ready <= 1'b1;
            end else if (r < 96) begin
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(10, 50)) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_distances.size() == 0) begin
            $display("%0t: unexpected item, distance %0d", $time, rsp_distance);
            error_count++;
         end else begin
            logic [COORD_BITS:0] want;
            want = expected_distances.pop_front();
            if (rsp_distance !== want) begin
               $display("%0t: distance mismatch, expected %0d, actual %0d",
                        $time, want, rsp_distance);
               error_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("torus_wrapped_distance_tb NOT OK");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
